>>> src/urlpd_pkg.sv
// Shared types, codes and helpers for the URL-encoded pair decoder.
// Used by urlpd_decode, urlpd_emit and urlencoded_pair_decoder.
`timescale 1ns / 1ps
`default_nettype none

package urlpd_pkg;

  localparam logic [7:0] NameLimitReset = 8'd31;
  localparam logic [7:0] ChPercent      = 8'h25;
  localparam logic [7:0] ChPlus         = 8'h2B;
  localparam logic [7:0] ChAmp          = 8'h26;
  localparam logic [7:0] ChEqual        = 8'h3D;
  localparam logic [7:0] ChQuestion     = 8'h3F;
  localparam logic [7:0] ChSpace        = 8'h20;

  localparam logic CfgQueryMode = 1'b0;
  localparam logic CfgNameLimit = 1'b1;

  localparam logic [2:0] KindPath    = 3'd0;
  localparam logic [2:0] KindName    = 3'd1;
  localparam logic [2:0] KindValue   = 3'd2;
  localparam logic [2:0] KindPathEnd = 3'd3;
  localparam logic [2:0] KindNameEnd = 3'd4;
  localparam logic [2:0] KindPairEnd = 3'd5;

  typedef enum logic [2:0] {
    PH_PATH  = 3'b001,
    PH_NAME  = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       malformed;
    logic       name_cut;
  } res_t;

  // up to three results caused by one input beat
  typedef struct packed {
    logic [1:0]       count;
    res_t [2:0]       res;
  } bundle_t;

  // {bad, nibble}: bad set for a non-hex character, nibble then zero
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
        d = c - 8'h30;
      end else if (c inside {[8'h61:8'h66]}) begin
        d = c - 8'h57;
      end else if (c inside {[8'h41:8'h46]}) begin
        d = c - 8'h37;
      end else begin
        d = 8'h10;
      end
      hex_nibble = d[4:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/urlpd_decode.sv
// Decoder state and per-beat decision logic: builds the result bundle for one
// input beat and updates the parse state. Depends on urlpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urlpd_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              in_fire,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_is_end,
  output urlpd_pkg::bundle_t     bnd
);

  logic               query_mode_r, query_mode_nxt;
  logic [7:0]         name_limit_r, name_limit_nxt;
  urlpd_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]         esc_cnt_r, esc_cnt_nxt;
  logic [7:0]         esc_val_r, esc_val_nxt;
  logic               esc_bad_r, esc_bad_nxt;
  logic [7:0]         name_len_r, name_len_nxt;
  logic               pair_open_r, pair_open_nxt;
  logic               name_over_r, name_over_nxt;

  urlpd_pkg::phase_t  ph;
  logic [2:0]         bkind;
  logic               delim;
  logic               go_on;
  logic [4:0]         hx;
  logic [1:0]         n;

  always_comb begin
    query_mode_nxt = query_mode_r;
    name_limit_nxt = name_limit_r;
    phase_nxt      = phase_r;
    esc_cnt_nxt    = esc_cnt_r;
    esc_val_nxt    = esc_val_r;
    esc_bad_nxt    = esc_bad_r;
    name_len_nxt   = name_len_r;
    pair_open_nxt  = pair_open_r;
    name_over_nxt  = name_over_r;
    bnd            = '0;
    n              = 2'd0;
    go_on          = 1'b1;
    hx             = urlpd_pkg::hex_nibble(in_data_byte);

    case (phase_r)
      urlpd_pkg::PH_PATH:  ph = urlpd_pkg::PH_PATH;
      urlpd_pkg::PH_VALUE: ph = urlpd_pkg::PH_VALUE;
      default:             ph = urlpd_pkg::PH_NAME;
    endcase

    case (ph)
      urlpd_pkg::PH_PATH:  bkind = urlpd_pkg::KindPath;
      urlpd_pkg::PH_NAME:  bkind = urlpd_pkg::KindName;
      default:             bkind = urlpd_pkg::KindValue;
    endcase

    delim = in_is_end
         || (ph == urlpd_pkg::PH_PATH && in_data_byte == urlpd_pkg::ChQuestion)
         || (ph == urlpd_pkg::PH_NAME && (in_data_byte == urlpd_pkg::ChEqual
                                       || in_data_byte == urlpd_pkg::ChAmp))
         || (ph == urlpd_pkg::PH_VALUE && in_data_byte == urlpd_pkg::ChAmp);

    if (cfg_we) begin
      if (cfg_index == urlpd_pkg::CfgQueryMode) begin
        query_mode_nxt = cfg_data[0];
        phase_nxt      = cfg_data[0] ? urlpd_pkg::PH_PATH : urlpd_pkg::PH_NAME;
        esc_cnt_nxt    = 2'd0;
        esc_val_nxt    = 8'd0;
        esc_bad_nxt    = 1'b0;
        name_len_nxt   = 8'd0;
        pair_open_nxt  = 1'b0;
        name_over_nxt  = 1'b0;
      end else begin
        name_limit_nxt = cfg_data;
      end
    end else if (in_fire) begin
      phase_nxt = ph;
      if (esc_cnt_r != 2'd0) begin
        if (delim) begin
          // escape cut short: flush what was gathered, then act on the delimiter
          bnd.res[n] = '{out_byte: esc_val_r, kind: bkind, malformed: 1'b1,
                         name_cut: 1'b0};
          n = n + 2'd1;
          esc_cnt_nxt = 2'd0;
          esc_val_nxt = 8'd0;
          esc_bad_nxt = 1'b0;
        end else begin
          go_on = 1'b0;
          esc_val_nxt = {esc_val_r[3:0], hx[4] ? 4'd0 : hx[3:0]};
          esc_bad_nxt = esc_bad_r | hx[4];
          if (esc_cnt_r == 2'd1) begin
            esc_cnt_nxt = 2'd2;
          end else begin
            bnd.res[n] = '{out_byte: esc_val_nxt, kind: bkind,
                           malformed: esc_bad_nxt, name_cut: 1'b0};
            n = n + 2'd1;
            esc_cnt_nxt = 2'd0;
            esc_val_nxt = 8'd0;
            esc_bad_nxt = 1'b0;
          end
        end
      end

      if (go_on) begin
        if (delim && (in_is_end || ph != urlpd_pkg::PH_PATH)
            && !(ph == urlpd_pkg::PH_NAME && !in_is_end
                 && in_data_byte == urlpd_pkg::ChEqual)
            && ph != urlpd_pkg::PH_PATH) begin
          // close the pair
          if (pair_open_r) begin
            if (ph == urlpd_pkg::PH_NAME) begin
              bnd.res[n] = '{out_byte: 8'd0, kind: urlpd_pkg::KindNameEnd,
                             malformed: 1'b0, name_cut: name_over_r};
              n = n + 2'd1;
            end
            bnd.res[n] = '{out_byte: 8'd0, kind: urlpd_pkg::KindPairEnd,
                           malformed: 1'b0, name_cut: name_over_r};
            n = n + 2'd1;
          end
          pair_open_nxt = 1'b0;
          name_len_nxt  = 8'd0;
          name_over_nxt = 1'b0;
          phase_nxt     = urlpd_pkg::PH_NAME;
        end else if (delim && ph == urlpd_pkg::PH_PATH) begin
          bnd.res[n] = '{out_byte: 8'd0, kind: urlpd_pkg::KindPathEnd,
                         malformed: 1'b0, name_cut: 1'b0};
          n = n + 2'd1;
          phase_nxt = urlpd_pkg::PH_NAME;
        end else if (delim) begin
          // '=' in the name phase
          pair_open_nxt = 1'b1;
          bnd.res[n] = '{out_byte: 8'd0, kind: urlpd_pkg::KindNameEnd,
                         malformed: 1'b0, name_cut: name_over_r};
          n = n + 2'd1;
          phase_nxt = urlpd_pkg::PH_VALUE;
        end else if (ph == urlpd_pkg::PH_NAME && !query_mode_r) begin
          pair_open_nxt = 1'b1;
          if (name_len_r < name_limit_r) begin
            bnd.res[n] = '{out_byte: in_data_byte, kind: urlpd_pkg::KindName,
                           malformed: 1'b0, name_cut: 1'b0};
            n = n + 2'd1;
            name_len_nxt = name_len_r + 8'd1;
          end else begin
            name_over_nxt = 1'b1;
          end
        end else begin
          if (ph == urlpd_pkg::PH_NAME) begin
            pair_open_nxt = 1'b1;
          end
          if (in_data_byte == urlpd_pkg::ChPlus) begin
            bnd.res[n] = '{out_byte: urlpd_pkg::ChSpace, kind: bkind,
                           malformed: 1'b0, name_cut: 1'b0};
            n = n + 2'd1;
          end else if (in_data_byte == urlpd_pkg::ChPercent) begin
            esc_cnt_nxt = 2'd1;
            esc_val_nxt = 8'd0;
            esc_bad_nxt = 1'b0;
          end else begin
            bnd.res[n] = '{out_byte: in_data_byte, kind: bkind,
                           malformed: 1'b0, name_cut: 1'b0};
            n = n + 2'd1;
          end
        end

        // end of string: restart the stream
        if (in_is_end) begin
          phase_nxt     = query_mode_r ? urlpd_pkg::PH_PATH : urlpd_pkg::PH_NAME;
          esc_cnt_nxt   = 2'd0;
          esc_val_nxt   = 8'd0;
          esc_bad_nxt   = 1'b0;
          name_len_nxt  = 8'd0;
          pair_open_nxt = 1'b0;
          name_over_nxt = 1'b0;
        end
      end
      bnd.count = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_mode_r <= 1'b0;
      name_limit_r <= urlpd_pkg::NameLimitReset;
      phase_r      <= urlpd_pkg::PH_NAME;
      esc_cnt_r    <= 2'd0;
      esc_val_r    <= 8'd0;
      esc_bad_r    <= 1'b0;
      name_len_r   <= 8'd0;
      pair_open_r  <= 1'b0;
      name_over_r  <= 1'b0;
    end else begin
      query_mode_r <= query_mode_nxt;
      name_limit_r <= name_limit_nxt;
      phase_r      <= phase_nxt;
      esc_cnt_r    <= esc_cnt_nxt;
      esc_val_r    <= esc_val_nxt;
      esc_bad_r    <= esc_bad_nxt;
      name_len_r   <= name_len_nxt;
      pair_open_r  <= pair_open_nxt;
      name_over_r  <= name_over_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/urlpd_emit.sv
// Result side: a pending bundle register feeding a serializer that sends one
// result beat per cycle while out_stall is low. Depends on urlpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urlpd_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire urlpd_pkg::bundle_t bnd,
  output logic                    busy,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_out_byte,
  output logic [2:0]              out_kind,
  output logic                    out_malformed,
  output logic                    out_name_cut,
  output logic                    out_last_result
);

  logic                pend_valid_r, pend_valid_nxt;
  urlpd_pkg::bundle_t  pend_r;
  logic                ser_valid_r, ser_valid_nxt;
  urlpd_pkg::bundle_t  ser_r;
  logic [1:0]          idx_r, idx_nxt;
  logic                last;
  logic                ser_done;
  logic                ser_free;
  logic                xfer;
  urlpd_pkg::res_t     cur;

  assign cur      = ser_r.res[idx_r];
  assign last     = (idx_r == ser_r.count - 2'd1);
  assign ser_done = ser_valid_r && !out_stall && last;
  assign ser_free = !ser_valid_r || ser_done;
  assign xfer     = pend_valid_r && ser_free;
  assign busy     = pend_valid_r && !ser_free;

  assign out_valid       = ser_valid_r;
  assign out_out_byte    = cur.out_byte;
  assign out_kind        = cur.kind;
  assign out_malformed   = cur.malformed;
  assign out_name_cut    = cur.name_cut;
  assign out_last_result = last;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    ser_valid_nxt  = ser_valid_r;
    idx_nxt        = idx_r;
    if (ser_valid_r && !out_stall) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (ser_done) begin
      ser_valid_nxt = 1'b0;
    end
    if (xfer) begin
      ser_valid_nxt  = 1'b1;
      idx_nxt        = 2'd0;
      pend_valid_nxt = 1'b0;
    end
    if (load) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      ser_valid_r  <= 1'b0;
      idx_r        <= 2'd0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      ser_valid_r  <= ser_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  // payload: hold unless a new bundle moves in
  always_ff @(posedge clk) begin
    if (load) begin
      pend_r <= bnd;
    end
    if (xfer) begin
      ser_r <= pend_r;
    end
  end

endmodule

`default_nettype wire

>>> src/urlencoded_pair_decoder.sv
// URL-encoded pair decoder, top level. Depends on urlpd_pkg, urlpd_decode
// and urlpd_emit.
// Result path: pending bundle register, then serializer register, then out.
// Throughput: one input beat per cycle while in_stall is low; a beat causing k
// results (k up to 3) holds the serializer until all are sent; zero results, no hold.
// Reset (rst_n low, synchronous): form mode, name limit 31, stream at start.
`timescale 1ns / 1ps
`default_nettype none

module urlencoded_pair_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_is_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_out_byte,
  output logic [2:0]       out_kind,
  output logic             out_malformed,
  output logic             out_name_cut,
  output logic             out_last_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic                in_fire;
  logic                cfg_we;
  logic                busy;
  urlpd_pkg::bundle_t  bnd;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  // hold input beats off while a register write goes in
  assign in_stall  = busy || cfg_valid;
  assign in_fire   = in_valid && !in_stall;

  urlpd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_data_byte (in_data_byte),
    .in_is_end    (in_is_end),
    .bnd          (bnd)
  );

  urlpd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_fire && !cfg_we && bnd.count != 2'd0),
    .bnd             (bnd),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_kind        (out_kind),
    .out_malformed   (out_malformed),
    .out_name_cut    (out_name_cut),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire

>>> tb/sv/urlencoded_pair_decoder_tb.sv
// Self-checking testbench for urlencoded_pair_decoder: directed table, then random text.
// Depends on urlpd_pkg for kinds, characters and register indexes; needs only the RTL.
`timescale 1ns / 1ps

module urlencoded_pair_decoder_tb;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       mal;
    logic       cut;
    logic       last;
  } result_beat_t;

  typedef enum logic [1:0] {
    ROW_CHAR,
    ROW_END,
    ROW_QUERY,
    ROW_LIMIT
  } row_op_t;

  // typed = 1: expectation comes from the row (has_res = 0 means no result at all)
  typedef struct packed {
    row_op_t    op;
    logic [7:0] val;
    logic       typed;
    logic       has_res;
    logic [7:0] b;
    logic [2:0] k;
    logic       m;
    logic       c;
  } stim_row_t;

  localparam int NumRows = 28;
  localparam stim_row_t DirectedRows [0:NumRows-1] = '{
    '{ROW_END,   8'h3D, 1'b1, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "a",   1'b1, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "=",   1'b1, 1'b1, 8'h00, urlpd_pkg::KindNameEnd, 1'b0, 1'b1},
    '{ROW_CHAR,  "=",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "%",   1'b1, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "A",   1'b1, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "x",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "&",   1'b1, 1'b1, 8'h00, urlpd_pkg::KindPairEnd, 1'b0, 1'b1},
    '{ROW_LIMIT, 8'hFF, 1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  8'hFF, 1'b1, 1'b1, 8'hFF, urlpd_pkg::KindName,    1'b0, 1'b0},
    '{ROW_CHAR,  "%",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "&",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_QUERY, 8'h01, 1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "+",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "%",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "3",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "f",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "?",   1'b1, 1'b1, 8'h00, urlpd_pkg::KindPathEnd, 1'b0, 1'b0},
    '{ROW_CHAR,  "%",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "=",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "%",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "4",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "1",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  "%",   1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_END,   8'h00, 1'b0, 1'b0, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_CHAR,  8'h00, 1'b1, 1'b1, 8'h00, urlpd_pkg::KindPath,    1'b0, 1'b0},
    '{ROW_END,   8'hFF, 1'b1, 1'b1, 8'h00, urlpd_pkg::KindPathEnd, 1'b0, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_is_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_byte;
  logic [2:0] out_kind;
  logic       out_malformed;
  logic       out_name_cut;
  logic       out_last_result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  urlencoded_pair_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_is_end      (in_is_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_kind       (out_kind),
    .out_malformed  (out_malformed),
    .out_name_cut   (out_name_cut),
    .out_last_result(out_last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  result_beat_t expected_beats[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;

  // decoder state as the testbench tracks it
  logic              mode_query;
  logic [7:0]        limit_names;
  urlpd_pkg::phase_t dec_phase;
  logic [1:0]        esc_digits;
  logic [7:0]        esc_acc;
  logic              esc_bad;
  logic [7:0]        name_kept;
  logic              pair_begun;
  logic              name_dropped;

  function automatic void push_result(input logic [7:0] b, input logic [2:0] k,
                                      input logic m, input logic c);
    expected_beats.push_back({b, k, m, c, 1'b0});
  endfunction

  function automatic void restart_stream();
    dec_phase    = mode_query ? urlpd_pkg::PH_PATH : urlpd_pkg::PH_NAME;
    esc_digits   = 2'd0;
    esc_acc      = 8'h00;
    esc_bad      = 1'b0;
    name_kept    = 8'h00;
    pair_begun   = 1'b0;
    name_dropped = 1'b0;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic void close_pair();
    if (pair_begun) begin
      if (dec_phase == urlpd_pkg::PH_NAME) begin
        push_result(8'h00, urlpd_pkg::KindNameEnd, 1'b0, name_dropped);
      end
      push_result(8'h00, urlpd_pkg::KindPairEnd, 1'b0, name_dropped);
    end
    pair_begun   = 1'b0;
    name_kept    = 8'h00;
    name_dropped = 1'b0;
    dec_phase    = urlpd_pkg::PH_NAME;
  endfunction

  // advance the tracked state by one input beat, queue its results, return how many
  function automatic int decode_beat(input logic [7:0] ch, input logic fin);
    int start;
    logic delim;
    logic [2:0] bkind;
    logic [4:0] nib;
    result_beat_t tail;
    start = expected_beats.size();
    bkind = (dec_phase == urlpd_pkg::PH_PATH) ? urlpd_pkg::KindPath :
            (dec_phase == urlpd_pkg::PH_NAME) ? urlpd_pkg::KindName : urlpd_pkg::KindValue;
    delim = fin
         || (dec_phase == urlpd_pkg::PH_PATH && ch == urlpd_pkg::ChQuestion)
         || (dec_phase == urlpd_pkg::PH_NAME
             && (ch == urlpd_pkg::ChEqual || ch == urlpd_pkg::ChAmp))
         || (dec_phase == urlpd_pkg::PH_VALUE && ch == urlpd_pkg::ChAmp);
    if (esc_digits != 2'd0 && !delim) begin
      nib = hex_value(ch);
      if (nib[4]) esc_bad = 1'b1;
      esc_acc = {esc_acc[3:0], nib[3:0]};
      if (esc_digits == 2'd1) begin
        esc_digits = 2'd2;
      end else begin
        push_result(esc_acc, bkind, esc_bad, 1'b0);
        esc_digits = 2'd0;
        esc_acc    = 8'h00;
        esc_bad    = 1'b0;
      end
    end else begin
      // a delimiter cuts a pending escape short
      if (esc_digits != 2'd0) begin
        push_result(esc_acc, bkind, 1'b1, 1'b0);
        esc_digits = 2'd0;
        esc_acc    = 8'h00;
        esc_bad    = 1'b0;
      end
      if (fin) begin
        if (dec_phase == urlpd_pkg::PH_PATH) begin
          push_result(8'h00, urlpd_pkg::KindPathEnd, 1'b0, 1'b0);
        end else begin
          close_pair();
        end
        restart_stream();
      end else if (delim) begin
        if (dec_phase == urlpd_pkg::PH_PATH) begin
          push_result(8'h00, urlpd_pkg::KindPathEnd, 1'b0, 1'b0);
          dec_phase = urlpd_pkg::PH_NAME;
        end else if (dec_phase == urlpd_pkg::PH_NAME && ch == urlpd_pkg::ChEqual) begin
          pair_begun = 1'b1;
          push_result(8'h00, urlpd_pkg::KindNameEnd, 1'b0, name_dropped);
          dec_phase = urlpd_pkg::PH_VALUE;
        end else begin
          close_pair();
        end
      end else if (dec_phase == urlpd_pkg::PH_NAME && !mode_query) begin
        pair_begun = 1'b1;
        if (name_kept < limit_names) begin
          push_result(ch, urlpd_pkg::KindName, 1'b0, 1'b0);
          name_kept++;
        end else begin
          name_dropped = 1'b1;
        end
      end else begin
        if (dec_phase == urlpd_pkg::PH_NAME) pair_begun = 1'b1;
        if (ch == urlpd_pkg::ChPlus) begin
          push_result(urlpd_pkg::ChSpace, bkind, 1'b0, 1'b0);
        end else if (ch == urlpd_pkg::ChPercent) begin
          esc_digits = 2'd1;
          esc_acc    = 8'h00;
          esc_bad    = 1'b0;
        end else begin
          push_result(ch, bkind, 1'b0, 1'b0);
        end
      end
    end
    if (expected_beats.size() > start) begin
      tail = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    end
    return expected_beats.size() - start;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic fin, output int produced);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_is_end    <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    produced = decode_beat(b, fin);
  endtask

  // drop valid and hold until every queued result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == urlpd_pkg::CfgQueryMode) begin
      mode_query = val[0];
      restart_stream();
    end else begin
      limit_names = val;
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return 8'h30 + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 4'd10;
  endfunction

  task automatic send_token();
    int r;
    int unused;
    logic [7:0] odd;
    r = $urandom_range(99);
    if (r < 50) begin
      send_beat(8'(8'h61 + $urandom_range(25)), 1'b0, unused);
    end else if (r < 60) begin
      send_beat(urlpd_pkg::ChPlus, 1'b0, unused);
    end else if (r < 88) begin
      send_beat(urlpd_pkg::ChPercent, 1'b0, unused);
      if (r < 84) begin
        send_beat(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0, unused);
      end
      if (r < 78) begin
        send_beat(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0, unused);
      end else if (r < 84) begin
        // non-hex second digit
        send_beat(8'(8'h67 + $urandom_range(19)), 1'b0, unused);
      end
    end else if (r < 95) begin
      send_beat(8'($urandom_range(255)), 1'b0, unused);
    end else begin
      case ($urandom_range(4))
        0: odd = urlpd_pkg::ChQuestion;
        1: odd = urlpd_pkg::ChEqual;
        2: odd = urlpd_pkg::ChPercent;
        3: odd = urlpd_pkg::ChPlus;
        default: odd = urlpd_pkg::ChAmp;
      endcase
      send_beat(odd, 1'b0, unused);
    end
  endtask

  // one string: optional path, a few name=value pairs, then the end marker
  task automatic send_text();
    int len;
    int unused;
    if (mode_query && $urandom_range(3) != 0) begin
      len = $urandom_range(4);
      repeat (len) send_token();
      send_beat(urlpd_pkg::ChQuestion, 1'b0, unused);
    end
    repeat ($urandom_range(1, 3)) begin
      len = $urandom_range(5);
      repeat (len) send_token();
      if ($urandom_range(4) != 0) begin
        send_beat(urlpd_pkg::ChEqual, 1'b0, unused);
        len = $urandom_range(5);
        repeat (len) send_token();
      end
      if ($urandom_range(5) != 0) send_beat(urlpd_pkg::ChAmp, 1'b0, unused);
    end
    send_beat(8'($urandom_range(255)), 1'b1, unused);
  endtask

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
        rx_hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_beat_t want;
    result_beat_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_out_byte, out_kind, out_malformed, out_name_cut, out_last_result};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat: byte %02h kind %0d mal %0b cut %0b last %0b",
                 $time, got.data, got.kind, got.mal, got.cut, got.last);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (got.data !== want.data || got.kind !== want.kind || got.mal !== want.mal ||
            got.cut !== want.cut || got.last !== want.last) begin
          $display("%0t: expected byte %02h kind %0d mal %0b cut %0b last %0b", $time,
                   want.data, want.kind, want.mal, want.cut, want.last);
          $display("%0t:      got byte %02h kind %0d mal %0b cut %0b last %0b", $time,
                   got.data, got.kind, got.mal, got.cut, got.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("urlencoded_pair_decoder_tb: FAIL");
    $finish;
  end

  initial begin
    stim_row_t row;
    int produced;
    int goal;
    int waited;
    mode_query  = 1'b0;
    limit_names = urlpd_pkg::NameLimitReset;
    restart_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      row = DirectedRows[i];
      case (row.op)
        ROW_QUERY: cfg_write(urlpd_pkg::CfgQueryMode, row.val);
        ROW_LIMIT: cfg_write(urlpd_pkg::CfgNameLimit, row.val);
        default: begin
          send_beat(row.val, row.op == ROW_END, produced);
          if (row.typed) begin
            // replace the computed results by the ones written in the row
            repeat (produced) void'(expected_beats.pop_back());
            if (row.has_res) expected_beats.push_back({row.b, row.k, row.m, row.c, 1'b1});
          end
        end
      endcase
    end

    tx_idle_pct = 25;
    rx_idle_pct = 76;
    cfg_write(urlpd_pkg::CfgQueryMode, 8'h00);
    cfg_write(urlpd_pkg::CfgNameLimit, 8'd3);
    goal = items_sent + 20;
    while (items_sent < goal) send_text();

    tx_idle_pct = 76;
    rx_idle_pct = 25;
    cfg_write(urlpd_pkg::CfgQueryMode, 8'h01);
    cfg_write(urlpd_pkg::CfgNameLimit, 8'd1);
    goal = items_sent + 20;
    while (items_sent < goal) send_text();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    cfg_write(urlpd_pkg::CfgQueryMode, 8'h00);
    cfg_write(urlpd_pkg::CfgNameLimit, 8'd2);
    // hold the output off long enough to back the block up into its input
    rx_hold_left = 400;
    goal = items_sent + 10;
    while (items_sent < goal) send_text();
    wait_idle();
    cfg_write(urlpd_pkg::CfgQueryMode, 8'h01);
    goal = items_sent + 6;
    while (items_sent < goal) send_text();

    in_valid <= 1'b0;
    waited = 0;
    while (expected_beats.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_beats.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("urlencoded_pair_decoder_tb: PASS");
    end else begin
      $display("urlencoded_pair_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> urlencoded_pair_decoder.f
src/urlpd_pkg.sv
src/urlpd_decode.sv
src/urlpd_emit.sv
src/urlencoded_pair_decoder.sv
tb/sv/urlencoded_pair_decoder_tb.sv
